>>> rtl/core/pcp_pkg.sv
// Shared types, constants and the output clamp of the PID controller.
// No dependencies; every module of the controller imports this package.
`timescale 1ns / 1ps

package pcp_pkg;

    localparam int VALUE_W    = 32;
    localparam int GAIN_W     = 31;
    localparam int GAIN_FRAC  = 24;
    localparam int TIME_W     = 32;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_X_W   = VALUE_W + 1;
    localparam int SUM_W      = VALUE_W + 3;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_AUTO   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MANUAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOWER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_UPPER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_MEAS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd7;

    localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd1000;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] target;
        logic signed [VALUE_W-1:0] measurement;
        logic [TIME_W-1:0]         now_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] drive;
        logic                      fresh;
        logic                      auto_on;
    } t_out_item;

    typedef struct packed {
        logic [GAIN_W-1:0]         prop_gain;
        logic [GAIN_W-1:0]         integ_gain;
        logic [GAIN_W-1:0]         deriv_gain;
        logic signed [VALUE_W-1:0] out_lower;
        logic signed [VALUE_W-1:0] out_upper;
        logic [TIME_W-1:0]         sample_period_ms;
        logic                      prop_on_meas;
        logic                      reverse_acting;
    } t_cfg;

    // The upper limit is checked first; with crossed limits, a value above it gives it, any other the lower.
    function automatic logic signed [VALUE_W-1:0] clamp_val(
        input logic signed [SUM_W-1:0]   v,
        input logic signed [VALUE_W-1:0] lo,
        input logic signed [VALUE_W-1:0] hi
    );
        logic signed [SUM_W-1:0] lo_x;
        logic signed [SUM_W-1:0] hi_x;
        lo_x = {{(SUM_W-VALUE_W){lo[VALUE_W-1]}}, lo};
        hi_x = {{(SUM_W-VALUE_W){hi[VALUE_W-1]}}, hi};
        if (v > hi_x) begin
            clamp_val = hi;
        end else if (v < lo_x) begin
            clamp_val = lo;
        end else begin
            clamp_val = v[VALUE_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/pcp_gain_mul.sv
// Gain product: unsigned gain times signed difference, floored, saturated
// and optionally negated. Depends on pcp_pkg.
`timescale 1ns / 1ps

module pcp_gain_mul (
    input  logic [pcp_pkg::GAIN_W-1:0]          i_gain,
    input  logic signed [pcp_pkg::PROD_X_W-1:0] i_x,
    input  logic                                i_neg,
    output logic signed [pcp_pkg::PROD_X_W-1:0] o_prod
);
    import pcp_pkg::*;

    localparam int PROD_W = GAIN_W + 1 + PROD_X_W;

    localparam logic signed [PROD_W-1:0] SAT_HI =
        {{(PROD_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_LO =
        {{(PROD_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};

    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_shift;
    logic signed [VALUE_W-1:0]  w_sat;
    logic signed [PROD_X_W-1:0] w_ext;

    assign w_prod  = $signed({{(PROD_W-GAIN_W){1'b0}}, i_gain})
                   * $signed({{(PROD_W-PROD_X_W){i_x[PROD_X_W-1]}}, i_x});
    assign w_shift = w_prod >>> GAIN_FRAC;

    always_comb begin
        if (w_shift > SAT_HI) begin
            w_sat = SAT_HI[VALUE_W-1:0];
        end else if (w_shift < SAT_LO) begin
            w_sat = SAT_LO[VALUE_W-1:0];
        end else begin
            w_sat = w_shift[VALUE_W-1:0];
        end
    end

    assign w_ext  = {w_sat[VALUE_W-1], w_sat};
    assign o_prod = i_neg ? -w_ext : w_ext;

endmodule

>>> rtl/core/pcp_datapath.sv
// Controller state and the single-pass update for one item.
// Depends on pcp_pkg and pcp_gain_mul.
`timescale 1ns / 1ps

module pcp_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  pcp_pkg::t_in_item i_item,
    input  pcp_pkg::t_cfg     i_cfg,
    output pcp_pkg::t_out_item o_result
);
    import pcp_pkg::*;

    logic signed [VALUE_W-1:0] r_prev_meas;
    logic signed [VALUE_W-1:0] r_prev_drive;
    logic signed [VALUE_W-1:0] r_integ;
    logic [TIME_W-1:0]         r_prev_time;
    logic                      r_auto;

    logic signed [VALUE_W-1:0] n_prev_meas;
    logic signed [VALUE_W-1:0] n_prev_drive;
    logic signed [VALUE_W-1:0] n_integ;
    logic [TIME_W-1:0]         n_prev_time;
    logic                      n_auto;

    logic signed [PROD_X_W-1:0] w_err;
    logic signed [PROD_X_W-1:0] w_dm;
    logic signed [PROD_X_W-1:0] w_kp_x;
    logic signed [PROD_X_W-1:0] w_gi;
    logic signed [PROD_X_W-1:0] w_gp;
    logic signed [PROD_X_W-1:0] w_gd;
    logic signed [SUM_W-1:0]    w_acc;
    logic signed [SUM_W-1:0]    w_out_sum;
    logic signed [VALUE_W-1:0]  w_integ_new;
    logic signed [VALUE_W-1:0]  w_drive_new;
    logic [TIME_W-1:0]          w_elapsed;
    logic                       w_calc;

    assign w_err = {i_item.target[VALUE_W-1], i_item.target}
                 - {i_item.measurement[VALUE_W-1], i_item.measurement};
    assign w_dm  = {i_item.measurement[VALUE_W-1], i_item.measurement}
                 - {r_prev_meas[VALUE_W-1], r_prev_meas};
    assign w_kp_x = i_cfg.prop_on_meas ? w_dm : w_err;

    pcp_gain_mul u_mul_i (
        .i_gain (i_cfg.integ_gain),
        .i_x    (w_err),
        .i_neg  (i_cfg.reverse_acting),
        .o_prod (w_gi)
    );

    pcp_gain_mul u_mul_p (
        .i_gain (i_cfg.prop_gain),
        .i_x    (w_kp_x),
        .i_neg  (i_cfg.reverse_acting),
        .o_prod (w_gp)
    );

    pcp_gain_mul u_mul_d (
        .i_gain (i_cfg.deriv_gain),
        .i_x    (w_dm),
        .i_neg  (i_cfg.reverse_acting),
        .o_prod (w_gd)
    );

    always_comb begin
        w_acc = {{(SUM_W-VALUE_W){r_integ[VALUE_W-1]}}, r_integ}
              + {{(SUM_W-PROD_X_W){w_gi[PROD_X_W-1]}}, w_gi};
        if (i_cfg.prop_on_meas) begin
            w_acc = w_acc - {{(SUM_W-PROD_X_W){w_gp[PROD_X_W-1]}}, w_gp};
        end
        w_integ_new = clamp_val(w_acc, i_cfg.out_lower, i_cfg.out_upper);
        w_out_sum = {{(SUM_W-VALUE_W){w_integ_new[VALUE_W-1]}}, w_integ_new}
                  - {{(SUM_W-PROD_X_W){w_gd[PROD_X_W-1]}}, w_gd};
        if (!i_cfg.prop_on_meas) begin
            w_out_sum = w_out_sum + {{(SUM_W-PROD_X_W){w_gp[PROD_X_W-1]}}, w_gp};
        end
        w_drive_new = clamp_val(w_out_sum, i_cfg.out_lower, i_cfg.out_upper);
    end

    assign w_elapsed = i_item.now_ms - r_prev_time;

    always_comb begin
        n_prev_meas  = r_prev_meas;
        n_prev_drive = r_prev_drive;
        n_integ      = r_integ;
        n_prev_time  = r_prev_time;
        n_auto       = r_auto;
        w_calc       = 1'b0;
        case (i_item.cmd)
            CMD_AUTO: begin
                if (!r_auto) begin
                    n_prev_meas = i_item.measurement;
                    n_integ = clamp_val(
                        {{(SUM_W-VALUE_W){r_prev_drive[VALUE_W-1]}}, r_prev_drive},
                        i_cfg.out_lower, i_cfg.out_upper);
                end
                n_auto = 1'b1;
            end
            CMD_MANUAL: begin
                n_auto = 1'b0;
            end
            CMD_SAMPLE: begin
                if (r_auto && (w_elapsed >= i_cfg.sample_period_ms)) begin
                    w_calc       = 1'b1;
                    n_integ      = w_integ_new;
                    n_prev_drive = w_drive_new;
                    n_prev_meas  = i_item.measurement;
                    n_prev_time  = i_item.now_ms;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.drive   = n_prev_drive;
    assign o_result.fresh   = w_calc;
    assign o_result.auto_on = n_auto;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_meas  <= '0;
            r_prev_drive <= '0;
            r_integ      <= '0;
            r_prev_time  <= '0;
            r_auto       <= 1'b0;
        end else if (i_fire) begin
            r_prev_meas  <= n_prev_meas;
            r_prev_drive <= n_prev_drive;
            r_integ      <= n_integ;
            r_prev_time  <= n_prev_time;
            r_auto       <= n_auto;
        end
    end

endmodule

>>> rtl/core/pid_controller_pone_ponm.sv
// Top level of the fixed-point PID controller: handshake, configuration
// registers, input and result registers. Depends on pcp_pkg and pcp_datapath.
//
// Items arrive on the input channel (i_in_valid, o_in_stall, i_in_item) and
// each produces exactly one result on the output channel (o_out_valid,
// i_out_stall, o_out_item). A transfer happens at a clock edge where valid is
// high and stall is low. An accepted item is held in the input register; once
// the result register can take a new value, the state update and the result
// are computed in a single combinational pass and captured in the result
// register, from which the result transfers. While the receiver does not
// stall, one item is accepted per cycle; the pass through the three gain
// multipliers and the clamps sets the clock period, not the throughput.
// When the receiver stalls, the result register holds its value and one more
// item waits in the input register; after that the input stalls too.
// Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data, only while no item is in flight: a rule for the user that the
// block does not enforce. Synchronous reset empties both registers, puts the
// controller in manual mode with zero state and loads register reset values.
`timescale 1ns / 1ps

module pid_controller_pone_ponm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pcp_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pcp_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_we,
    input  logic [pcp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pcp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pcp_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;

    logic      n_in_vld;
    logic      n_out_vld;
    logic      w_adv_out;
    logic      w_fire;
    logic      w_accept;
    t_out_item w_result;

    assign w_adv_out  = !r_out_vld || !i_out_stall;
    assign w_fire     = r_in_vld && w_adv_out;
    assign o_in_stall = r_in_vld && !w_adv_out;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    pcp_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_comb begin
        if (w_accept) begin
            n_in_vld = 1'b1;
        end else if (w_fire) begin
            n_in_vld = 1'b0;
        end else begin
            n_in_vld = r_in_vld;
        end
        if (w_fire) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_in_item;
        end
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain        <= '0;
            r_cfg.integ_gain       <= '0;
            r_cfg.deriv_gain       <= '0;
            r_cfg.out_lower        <= '0;
            r_cfg.out_upper        <= '0;
            r_cfg.sample_period_ms <= PERIOD_RESET;
            r_cfg.prop_on_meas     <= 1'b0;
            r_cfg.reverse_acting   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP_GAIN:  r_cfg.prop_gain        <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN: r_cfg.integ_gain       <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN: r_cfg.deriv_gain       <= i_cfg_data[GAIN_W-1:0];
                REG_OUT_LOWER:  r_cfg.out_lower        <= i_cfg_data[VALUE_W-1:0];
                REG_OUT_UPPER:  r_cfg.out_upper        <= i_cfg_data[VALUE_W-1:0];
                REG_PERIOD:     r_cfg.sample_period_ms <= i_cfg_data[TIME_W-1:0];
                REG_PROP_MEAS:  r_cfg.prop_on_meas     <= i_cfg_data[0];
                REG_REVERSE:    r_cfg.reverse_acting   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> verif/pid_controller_pone_ponm_tb.sv
// Self-checking testbench for the fixed-point PID controller: a directed table, then random
// register settings and command streams, checked against a row's expected values or else an
// in-bench controller model. Depends on pcp_pkg and the pid_controller_pone_ponm top level.
`timescale 1ns / 1ps

module pid_controller_pone_ponm_tb;
    import pcp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic signed [VALUE_W-1:0] V_TOP = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] V_BOT = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS   = 150;
    localparam int QUIET_LIMIT   = 400;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        t_in_item               item;
        logic                   has_exp;
        t_out_item              exp;
    } t_stim_row;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_cfg                       ctl;
    logic signed [VALUE_W-1:0]  held_meas;
    logic signed [VALUE_W-1:0]  held_drive;
    logic signed [VALUE_W-1:0]  integ_acc;
    logic [TIME_W-1:0]          last_calc_ms;
    logic                       in_auto;
    t_out_item                  pending_outputs[$];

    logic        tx_idle = 1'b1;
    logic        rx_idle = 1'b1;
    logic [31:0] gen_now = '0;
    int          rx_hold = 0;
    int          quiet_cycles = 0;
    int          fail_count = 0;
    int          item_count = 0;
    int          result_count = 0;
    int          fresh_count = 0;
    int          setting_count = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pid_controller_pone_ponm DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    function automatic void reset_model();
        ctl = '0;
        ctl.sample_period_ms = PERIOD_RESET;
        held_meas = '0;
        held_drive = '0;
        integ_acc = '0;
        last_calc_ms = '0;
        in_auto = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PROP_GAIN:  ctl.prop_gain = data[GAIN_W-1:0];
            REG_INTEG_GAIN: ctl.integ_gain = data[GAIN_W-1:0];
            REG_DERIV_GAIN: ctl.deriv_gain = data[GAIN_W-1:0];
            REG_OUT_LOWER:  ctl.out_lower = data[VALUE_W-1:0];
            REG_OUT_UPPER:  ctl.out_upper = data[VALUE_W-1:0];
            REG_PERIOD:     ctl.sample_period_ms = data[TIME_W-1:0];
            REG_PROP_MEAS:  ctl.prop_on_meas = data[0];
            REG_REVERSE:    ctl.reverse_acting = data[0];
            default: ;
        endcase
    endfunction

    // Gain times value, floored to the value scale, saturated, sign flipped for reverse action.
    function automatic longint scaled_product(input logic [GAIN_W-1:0] g, input longint x);
        logic [63:0] mag;
        logic [63:0] q;
        logic        frac_left;
        longint      r;
        mag = (x < 0) ? 64'(-x) : 64'(x);
        mag = mag * 64'(g);
        q = mag >> GAIN_FRAC;
        frac_left = |mag[GAIN_FRAC-1:0];
        if (x < 0) begin
            q = q + 64'(frac_left);
            r = (q > 64'(longint'(V_TOP)) + 64'd1) ? longint'(V_BOT) : -longint'(q);
        end else begin
            r = (q > 64'(longint'(V_TOP))) ? longint'(V_TOP) : longint'(q);
        end
        if (ctl.reverse_acting) begin
            r = -r;
        end
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] limit_val(input longint v);
        if (v > longint'($signed(ctl.out_upper))) begin
            return ctl.out_upper;
        end else if (v < longint'($signed(ctl.out_lower))) begin
            return ctl.out_lower;
        end
        return v[VALUE_W-1:0];
    endfunction

    function automatic t_out_item pid_step(input t_in_item it);
        longint            err;
        longint            dm;
        longint            acc;
        longint            o;
        logic [TIME_W-1:0] elapsed;
        t_out_item         res;
        res.fresh = 1'b0;
        elapsed = it.now_ms - last_calc_ms;
        case (it.cmd)
            CMD_AUTO: begin
                if (!in_auto) begin
                    held_meas = it.measurement;
                    integ_acc = limit_val(longint'($signed(held_drive)));
                end
                in_auto = 1'b1;
            end
            CMD_MANUAL: begin
                in_auto = 1'b0;
            end
            CMD_SAMPLE: begin
                if (in_auto && elapsed >= ctl.sample_period_ms) begin
                    err = longint'($signed(it.target)) - longint'($signed(it.measurement));
                    dm = longint'($signed(it.measurement)) - longint'($signed(held_meas));
                    acc = longint'($signed(integ_acc)) + scaled_product(ctl.integ_gain, err);
                    if (ctl.prop_on_meas) begin
                        acc = acc - scaled_product(ctl.prop_gain, dm);
                    end
                    integ_acc = limit_val(acc);
                    o = longint'($signed(integ_acc)) - scaled_product(ctl.deriv_gain, dm);
                    if (!ctl.prop_on_meas) begin
                        o = o + scaled_product(ctl.prop_gain, err);
                    end
                    held_drive = limit_val(o);
                    held_meas = it.measurement;
                    last_calc_ms = it.now_ms;
                    res.fresh = 1'b1;
                end
            end
            default: ;
        endcase
        res.drive = held_drive;
        res.auto_on = in_auto;
        return res;
    endfunction

    function automatic t_stim_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r.kind = ROW_REG;
        r.idx = idx;
        r.data = data;
        r.item = '0;
        r.has_exp = 1'b0;
        r.exp = '0;
        return r;
    endfunction

    function automatic t_stim_row item_row(input logic [CMD_W-1:0] cmd, input logic [31:0] tgt,
                                           input logic [31:0] meas, input logic [31:0] now);
        t_stim_row r;
        r.kind = ROW_ITEM;
        r.idx = '0;
        r.data = '0;
        r.item.cmd = cmd;
        r.item.target = tgt;
        r.item.measurement = meas;
        r.item.now_ms = now;
        r.has_exp = 1'b0;
        r.exp = '0;
        return r;
    endfunction

    function automatic t_stim_row item_chk(input logic [CMD_W-1:0] cmd, input logic [31:0] tgt,
                                           input logic [31:0] meas, input logic [31:0] now,
                                           input logic [31:0] drv, input logic fr, input logic au);
        t_stim_row r;
        r = item_row(cmd, tgt, meas, now);
        r.has_exp = 1'b1;
        r.exp.drive = drv;
        r.exp.fresh = fr;
        r.exp.auto_on = au;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 15))
            0:       v = V_TOP;
            1:       v = V_BOT;
            2, 3:    v = $urandom();
            default: v = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_gain();
        logic [31:0] g;
        case ($urandom_range(0, 9))
            0:       g = '0;
            1:       g = '1;
            2, 3:    g = $urandom();
            default: begin
                g = $urandom_range(0, 32'h0400_0000);
                g[31] = $urandom_range(0, 1);
            end
        endcase
        return g;
    endfunction

    task automatic push_item(input t_in_item it, input logic has_exp, input t_out_item typed);
        int        gap;
        t_out_item calc;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        calc = pid_step(it);
        pending_outputs.push_back(has_exp ? typed : calc);
        item_count++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    task automatic random_setup();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] a;
        logic [31:0] per;
        settle();
        write_reg(REG_PROP_GAIN, pick_gain());
        write_reg(REG_INTEG_GAIN, pick_gain());
        write_reg(REG_DERIV_GAIN, pick_gain());
        case ($urandom_range(0, 5))
            0: begin
                lo = V_BOT;
                hi = V_TOP;
            end
            1: begin
                lo = $urandom();
                hi = $urandom();
            end
            2: begin
                a = $urandom_range(1, 32'h0100_0000);
                lo = a;
                hi = -a;
            end
            default: begin
                a = $urandom_range(1, 32'h0200_0000);
                lo = -a;
                hi = a;
            end
        endcase
        write_reg(REG_OUT_LOWER, lo);
        write_reg(REG_OUT_UPPER, hi);
        case ($urandom_range(0, 7))
            0:       per = '0;
            1:       per = '1;
            2:       per = 32'd1;
            3:       per = 32'd1000;
            default: per = $urandom_range(1, 50);
        endcase
        write_reg(REG_PERIOD, per);
        write_reg(REG_PROP_MEAS, $urandom());
        write_reg(REG_REVERSE, $urandom());
        cfg_we <= 1'b0;
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        setting_count++;
    endtask

    task automatic random_phase(input int count);
        t_in_item    it;
        t_out_item   none;
        logic [31:0] tgt;
        logic [31:0] short_per;
        int unsigned r;
        logic        lead;
        none = '0;
        tgt = pick_value();
        lead = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (k == 0 && lead) begin
                it.cmd = CMD_AUTO;
            end else if (r < 82) begin
                it.cmd = CMD_SAMPLE;
            end else if (r < 90) begin
                it.cmd = CMD_AUTO;
            end else if (r < 96) begin
                it.cmd = CMD_MANUAL;
            end else begin
                it.cmd = CMD_SPARE;
            end
            if ($urandom_range(0, 9) == 0) begin
                tgt = pick_value();
            end
            it.target = tgt;
            if ($urandom_range(0, 4) == 0) begin
                it.measurement = pick_value();
            end else begin
                it.measurement = tgt + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            end
            short_per = (ctl.sample_period_ms > 64) ? 32'd64 : ctl.sample_period_ms;
            case ($urandom_range(0, 9))
                0:          it.now_ms = gen_now;
                1:          it.now_ms = $urandom();
                2, 3, 4:    it.now_ms = last_calc_ms + ctl.sample_period_ms
                                        - $urandom_range(0, 1);
                default:    it.now_ms = gen_now + $urandom_range(0, 2 * short_per);
            endcase
            gen_now = it.now_ms;
            push_item(it, 1'b0, none);
        end
    endtask

    always @(posedge clk) begin : rx_side
        t_out_item want;
        if (!rst_n) begin
            rx_hold = 0;
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                result_count++;
                if (out_item.fresh === 1'b1) begin
                    fresh_count++;
                end
                if (pending_outputs.size() == 0) begin
                    $error("unexpected transfer with no item pending: drive %0d",
                           $signed(out_item.drive));
                    fail_count++;
                end else begin
                    want = pending_outputs.pop_front();
                    if (out_item.drive !== want.drive) begin
                        $error("drive: expected %0d, actual %0d",
                               $signed(want.drive), $signed(out_item.drive));
                        fail_count++;
                    end
                    if (out_item.fresh !== want.fresh) begin
                        $error("fresh: expected %0b, actual %0b", want.fresh, out_item.fresh);
                        fail_count++;
                    end
                    if (out_item.auto_on !== want.auto_on) begin
                        $error("auto_on: expected %0b, actual %0b",
                               want.auto_on, out_item.auto_on);
                        fail_count++;
                    end
                end
                rx_hold = rx_idle ? $urandom_range(0, 6) : 0;
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            out_stall <= (rx_hold != 0);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Stopped after %0d cycles without any transfer.", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_stim_row rows[$];
        logic      last_reg;
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(item_chk(CMD_SAMPLE, V_TOP, V_BOT, 32'd0, 32'd0, 1'b0, 1'b0));
        rows.push_back(item_chk(CMD_SPARE, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF,
                                32'd0, 1'b0, 1'b0));
        rows.push_back(item_chk(CMD_MANUAL, 32'd0, 32'd0, 32'd5, 32'd0, 1'b0, 1'b0));
        rows.push_back(item_chk(CMD_AUTO, 32'd0, 32'h0001_0000, 32'd10, 32'd0, 1'b0, 1'b1));
        rows.push_back(item_chk(CMD_SAMPLE, 32'd0, 32'd0, 32'd999, 32'd0, 1'b0, 1'b1));
        rows.push_back(item_chk(CMD_SAMPLE, V_TOP, V_BOT, 32'd1000, 32'd0, 1'b1, 1'b1));
        rows.push_back(item_chk(CMD_AUTO, 32'h0001_0000, 32'h0002_0000, 32'd1000,
                                32'd0, 1'b0, 1'b1));
        rows.push_back(reg_row(REG_PROP_GAIN, 32'hFFFF_FFFF));
        rows.push_back(reg_row(REG_INTEG_GAIN, 32'hFFFF_FFFF));
        rows.push_back(reg_row(REG_DERIV_GAIN, 32'hFFFF_FFFF));
        rows.push_back(reg_row(REG_OUT_LOWER, V_BOT));
        rows.push_back(reg_row(REG_OUT_UPPER, V_TOP));
        rows.push_back(reg_row(REG_PERIOD, 32'd0));
        rows.push_back(reg_row(REG_PROP_MEAS, 32'd0));
        rows.push_back(reg_row(REG_REVERSE, 32'd0));
        rows.push_back(item_chk(CMD_SAMPLE, V_TOP, V_BOT, 32'd1000, V_TOP, 1'b1, 1'b1));
        rows.push_back(item_chk(CMD_SAMPLE, V_BOT, V_TOP, 32'd1000, V_BOT, 1'b1, 1'b1));
        rows.push_back(item_row(CMD_SAMPLE, 32'h0003_0000, 32'h0001_0000, 32'd1200));
        rows.push_back(item_row(CMD_MANUAL, 32'd0, 32'd0, 32'd1300));
        rows.push_back(item_row(CMD_AUTO, 32'd0, 32'h0002_0000, 32'd1500));
        rows.push_back(reg_row(REG_PROP_MEAS, 32'd1));
        rows.push_back(reg_row(REG_REVERSE, 32'd1));
        rows.push_back(item_row(CMD_SAMPLE, 32'h0001_8000, 32'hFFFF_0000, 32'd2000));
        rows.push_back(item_row(CMD_SAMPLE, V_BOT, V_TOP, 32'd2001));
        rows.push_back(reg_row(REG_OUT_LOWER, 32'h0010_0000));
        rows.push_back(reg_row(REG_OUT_UPPER, 32'hFFF0_0000));
        rows.push_back(reg_row(REG_PERIOD, 32'hFFFF_FFFF));
        rows.push_back(item_row(CMD_SAMPLE, 32'h0005_0000, 32'h0004_0000, 32'd2000));
        rows.push_back(item_row(CMD_SAMPLE, 32'h0005_0000, 32'h0004_0000, 32'd2000));
        rows.push_back(item_row(CMD_SAMPLE, 32'hFFFB_0000, 32'h0004_0000, 32'd1999));
        rows.push_back(reg_row(REG_PROP_GAIN, 32'h0100_0000));
        rows.push_back(reg_row(REG_INTEG_GAIN, 32'h0008_0000));
        rows.push_back(reg_row(REG_DERIV_GAIN, 32'h0040_0000));
        rows.push_back(reg_row(REG_OUT_LOWER, 32'hFF9C_0000));
        rows.push_back(reg_row(REG_OUT_UPPER, 32'h0064_0000));
        rows.push_back(reg_row(REG_PERIOD, 32'd1));
        rows.push_back(reg_row(REG_PROP_MEAS, 32'd0));
        rows.push_back(reg_row(REG_REVERSE, 32'd0));
        rows.push_back(item_row(CMD_SAMPLE, 32'h000A_0000, 32'h0002_0000, 32'd0));
        rows.push_back(item_row(CMD_SAMPLE, 32'h000A_0000, 32'h0003_0000, 32'd0));
        rows.push_back(item_row(CMD_SAMPLE, 32'h000A_0000, 32'h0004_8000, 32'd1));
        rows.push_back(item_row(CMD_SPARE, V_BOT, V_TOP, 32'd5));
        rows.push_back(item_row(CMD_SAMPLE, 32'hFFF6_0000, 32'h0001_0000, 32'hFFFF_FFFF));
        rows.push_back(item_row(CMD_SAMPLE, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        last_reg = 1'b0;
        foreach (rows[r]) begin
            if (rows[r].kind == ROW_REG) begin
                if (!last_reg) begin
                    settle();
                    setting_count++;
                end
                write_reg(rows[r].idx, rows[r].data);
                last_reg = 1'b1;
            end else begin
                if (last_reg) begin
                    cfg_we <= 1'b0;
                end
                push_item(rows[r].item, rows[r].has_exp, rows[r].exp);
                last_reg = 1'b0;
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_setup();
            random_phase(PHASE_ITEMS);
        end

        in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        $display("Sent %0d items across %0d register settings; %0d results compared,",
                 item_count, setting_count, result_count);
        $display("%0d of them freshly computed, %0d mismatches.", fresh_count, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
